// ===== rtl/eig2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eig2_pkg
// Shared constants for the 2x2 eigenvalue core: result word width and
// saturation limits of the eigenvalue outputs.
// ----------------------------------------------------------------------------
package eig2_pkg;

    // eigenvalue output width and its signed range
    localparam int unsigned OUT_WIDTH = 18;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -18'sh20000;

    typedef logic signed [OUT_WIDTH-1:0] t_lambda;

endpackage
`default_nettype wire

// ===== rtl/eig2_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eig2_front
// Three stage front end: trace and entry difference, the two products, and
// the discriminant (a - d)^2 + 4bc with its sign split off.
// ----------------------------------------------------------------------------
module eig2_front #(
    parameter int ELEM_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  signed [ELEM_WIDTH-1:0] i_a,
    input  wire  signed [ELEM_WIDTH-1:0] i_b,
    input  wire  signed [ELEM_WIDTH-1:0] i_c,
    input  wire  signed [ELEM_WIDTH-1:0] i_d,
    output logic                        o_valid,
    input  wire                         i_ready_next,
    output logic signed [ELEM_WIDTH:0]  o_trace,
    output logic [2*ELEM_WIDTH+1:0]     o_mag,
    output logic                        o_neg
);

    localparam int W  = ELEM_WIDTH;
    localparam int MW = 2 * W + 2;
    localparam int DW = 2 * W + 3;

    // stage valids and ready chain
    logic r_va, r_vb, r_vc;
    logic rdy_a, rdy_b, rdy_c;

    assign rdy_c   = !r_vc || i_ready_next;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    // stage a: trace and magnitude of a - d
    logic signed [W:0] n_trace_a, diff_a;
    logic [W:0]        n_adiff;
    logic signed [W:0] r_trace_a;
    logic [W:0]        r_adiff;
    logic signed [W-1:0] r_b, r_c;

    always_comb begin
        n_trace_a = {i_a[W-1], i_a} + {i_d[W-1], i_d};
        diff_a    = {i_a[W-1], i_a} - {i_d[W-1], i_d};
        n_adiff   = diff_a[W] ? (W+1)'(-diff_a) : (W+1)'(diff_a);
    end

    // stage b: square of the difference and the off-diagonal product
    logic [MW-1:0]         r_sq;
    logic signed [2*W-1:0] r_prod;
    logic signed [W:0]     r_trace_b;

    // stage c: discriminant and its sign
    logic signed [DW-1:0] sq_ext, p4_ext, disc;

    always_comb begin
        sq_ext = $signed({1'b0, r_sq});
        p4_ext = DW'($signed({r_prod, 2'b00}));
        disc   = sq_ext + p4_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_trace_a <= n_trace_a;
            r_adiff   <= n_adiff;
            r_b       <= i_b;
            r_c       <= i_c;
        end
        if (rdy_b) begin
            r_sq      <= r_adiff * r_adiff;
            r_prod    <= r_b * r_c;
            r_trace_b <= r_trace_a;
        end
        if (rdy_c) begin
            o_trace <= r_trace_b;
            o_neg   <= disc[DW-1];
            o_mag   <= disc[DW-1] ? '0 : disc[MW-1:0];
        end
    end

    assign o_valid = r_vc;

endmodule
`default_nettype wire

// ===== rtl/eig2_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eig2_sqrt_cell
// One digit of the restoring square root: shifts in the next bit pair of the
// radicand, tries root*4+1 against the remainder and settles one root bit.
// ----------------------------------------------------------------------------
module eig2_sqrt_cell #(
    parameter int ELEM_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [2*ELEM_WIDTH+1:0]      i_rad,
    input  wire  [ELEM_WIDTH+3:0]        i_rem,
    input  wire  [ELEM_WIDTH:0]          i_root,
    input  wire  signed [ELEM_WIDTH:0]   i_trace,
    input  wire                          i_neg,
    output logic                         o_valid,
    input  wire                          i_ready_next,
    output logic [2*ELEM_WIDTH+1:0]      o_rad,
    output logic [ELEM_WIDTH+3:0]        o_rem,
    output logic [ELEM_WIDTH:0]          o_root,
    output logic signed [ELEM_WIDTH:0]   o_trace,
    output logic                         o_neg
);

    localparam int MW  = 2 * ELEM_WIDTH + 2;
    localparam int RW  = ELEM_WIDTH + 1;
    localparam int RMW = ELEM_WIDTH + 4;

    logic r_valid;
    logic [RMW-1:0] rem_sh, trial, n_rem;
    logic [RW-1:0]  n_root;
    logic [MW-1:0]  n_rad;
    logic           take;

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;

    // trial subtract of one root digit
    always_comb begin
        rem_sh = {i_rem[RMW-3:0], i_rad[MW-1 -: 2]};
        trial  = {1'b0, i_root, 2'b01};
        take   = rem_sh >= trial;
        n_rem  = take ? rem_sh - trial : rem_sh;
        n_root = {i_root[RW-2:0], take};
        n_rad  = {i_rad[MW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_rad   <= n_rad;
            o_rem   <= n_rem;
            o_root  <= n_root;
            o_trace <= i_trace;
            o_neg   <= i_neg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/eig2_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eig2_back
// Output stage: halves trace plus and minus the root, saturates both roots to
// the result width and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module eig2_back
    import eig2_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [ELEM_WIDTH:0]         i_root,
    input  wire  signed [ELEM_WIDTH:0]  i_trace,
    input  wire                         i_neg,
    output logic                        o_valid,
    input  wire                         i_stall,
    output t_lambda                     o_high,
    output t_lambda                     o_low,
    output logic                        o_not_real
);

    localparam int W  = ELEM_WIDTH;
    localparam int SW = W + 2;
    localparam int CW = (SW > OUT_WIDTH) ? SW : OUT_WIDTH;
    localparam logic signed [CW-1:0] SAT_HI = CW'(OUT_MAX);
    localparam logic signed [CW-1:0] SAT_LO = CW'(OUT_MIN);

    logic r_valid;
    logic signed [W+2:0] sum_hi, sum_lo;
    logic signed [CW-1:0] half_hi, half_lo;
    t_lambda n_high, n_low;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;

    // floor halves of t + s and t - s, then clamp
    always_comb begin
        sum_hi  = {{2{i_trace[W]}}, i_trace} + $signed({2'b00, i_root});
        sum_lo  = {{2{i_trace[W]}}, i_trace} - $signed({2'b00, i_root});
        half_hi = CW'($signed(sum_hi[W+2:1]));
        half_lo = CW'($signed(sum_lo[W+2:1]));
        if (half_hi > SAT_HI)      n_high = OUT_MAX;
        else if (half_hi < SAT_LO) n_high = OUT_MIN;
        else                       n_high = half_hi[OUT_WIDTH-1:0];
        if (half_lo > SAT_HI)      n_low = OUT_MAX;
        else if (half_lo < SAT_LO) n_low = OUT_MIN;
        else                       n_low = half_lo[OUT_WIDTH-1:0];
        if (i_neg) begin
            n_high = '0;
            n_low  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_high     <= n_high;
            o_low      <= n_low;
            o_not_real <= i_neg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/eigenvalues_two_by_two_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eigenvalues_two_by_two_core
// Real eigenvalues of a signed fixed-point 2x2 matrix, one matrix per cycle.
// ----------------------------------------------------------------------------
// Takes one matrix word per cycle and returns the larger and smaller real
// eigenvalue (t +/- floor(sqrt((a-d)^2 + 4bc))) / 2, floored, with the input's
// fraction bits, saturated to 18 bits; a negative discriminant gives zeros
// and not_real. The path is three front stages (trace/difference, the two
// multipliers, discriminant), a row of ELEM_WIDTH + 1 square root cells that
// each settle one root bit, and the output register. Sustained rate is one
// word per cycle; every stage holds its word under stall and a bubble in any
// stage is filled by the next word.
// ----------------------------------------------------------------------------
module eigenvalues_two_by_two_core
    import eig2_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  signed [ELEM_WIDTH-1:0] i_entry_top_left,
    input  wire  signed [ELEM_WIDTH-1:0] i_entry_top_right,
    input  wire  signed [ELEM_WIDTH-1:0] i_entry_bottom_left,
    input  wire  signed [ELEM_WIDTH-1:0] i_entry_bottom_right,
    output logic                        o_valid,
    input  wire                         i_stall,
    output t_lambda                     o_lambda_high,
    output t_lambda                     o_lambda_low,
    output logic                        o_not_real
);

    localparam int W  = ELEM_WIDTH;
    localparam int NC = W + 1;
    localparam int MW = 2 * W + 2;

    // per-cell links of the square root row
    logic                c_valid [0:NC];
    logic                c_ready [0:NC];
    logic [MW-1:0]       c_rad   [0:NC];
    logic [W+3:0]        c_rem   [0:NC];
    logic [W:0]          c_root  [0:NC];
    logic signed [W:0]   c_trace [0:NC];
    logic                c_neg   [0:NC];
    logic                front_ready;

    // trace and discriminant
    eig2_front #(.ELEM_WIDTH(W)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (front_ready),
        .i_a          (i_entry_top_left),
        .i_b          (i_entry_top_right),
        .i_c          (i_entry_bottom_left),
        .i_d          (i_entry_bottom_right),
        .o_valid      (c_valid[0]),
        .i_ready_next (c_ready[0]),
        .o_trace      (c_trace[0]),
        .o_mag        (c_rad[0]),
        .o_neg        (c_neg[0])
    );

    assign o_stall   = !front_ready;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    // square root row, one root bit per cell
    for (genvar k = 0; k < NC; k++) begin : g_cell
        eig2_sqrt_cell #(.ELEM_WIDTH(W)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (c_valid[k]),
            .o_ready      (c_ready[k]),
            .i_rad        (c_rad[k]),
            .i_rem        (c_rem[k]),
            .i_root       (c_root[k]),
            .i_trace      (c_trace[k]),
            .i_neg        (c_neg[k]),
            .o_valid      (c_valid[k+1]),
            .i_ready_next (c_ready[k+1]),
            .o_rad        (c_rad[k+1]),
            .o_rem        (c_rem[k+1]),
            .o_root       (c_root[k+1]),
            .o_trace      (c_trace[k+1]),
            .o_neg        (c_neg[k+1])
        );
    end

    // roots, clamp and output word register
    eig2_back #(.ELEM_WIDTH(W)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c_valid[NC]),
        .o_ready    (c_ready[NC]),
        .i_root     (c_root[NC]),
        .i_trace    (c_trace[NC]),
        .i_neg      (c_neg[NC]),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_high     (o_lambda_high),
        .o_low      (o_lambda_low),
        .o_not_real (o_not_real)
    );

endmodule
`default_nettype wire
